// File: design/cascaded_pid_controller_defines.svh
// assertion macros of the cascaded pid controller, used by its sequencer
`ifndef CASCADED_PID_CONTROLLER_DEFINES_SVH
`define CASCADED_PID_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define CPID_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cpid assertion failed");
`define CPID_ASSERT_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> nxt) \
    else $error("cpid assertion failed");
`else
`define CPID_ASSERT(label, prop)
`define CPID_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

// File: design/cpid_pkg.sv
// types and constants of the cascaded pid controller
package cpid_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_INNER_KP    = 3'd0;
  localparam logic [2:0] REG_INNER_KI    = 3'd1;
  localparam logic [2:0] REG_INNER_KD    = 3'd2;
  localparam logic [2:0] REG_OUTER_KP    = 3'd3;
  localparam logic [2:0] REG_OUTER_KI    = 3'd4;
  localparam logic [2:0] REG_OUTER_KD    = 3'd5;
  localparam logic [2:0] REG_OUTER_TGT   = 3'd6;
  localparam logic [2:0] REG_OUTER_LIMIT = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // lower clamp of both loops
  localparam int LOOP_MIN = 0;

  localparam longint S32_MAX = 64'sd2147483647;

  // reset gains: inner kp 0.8, inner ki 0.002, outer kp 80, outer ki 20
  localparam longint INNER_KP_NUM = 4;
  localparam longint INNER_KP_DEN = 5;
  localparam longint INNER_KI_NUM = 2;
  localparam longint INNER_KI_DEN = 1000;
  localparam longint OUTER_KP_INT = 80;
  localparam longint OUTER_KI_INT = 20;
  localparam longint OUTER_LIMIT_INT = 3000;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_DIFF,
    OP_MULP,
    OP_MULD,
    OP_SUM,
    OP_FIN
  } op_t;

  typedef struct packed {
    logic capture;
    logic push;
    logic outer;
    op_t  op;
  } cmd_t;

endpackage

// File: design/cpid_ctrl.sv
// sequencer for the cascaded pid controller
`include "cascaded_pid_controller_defines.svh"

module cpid_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            req_type,
  output logic            out_valid,
  input  logic            out_stall,
  output cpid_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_DIFF = 8'b0000_0100,
    S_MULP = 8'b0000_1000,
    S_MULD = 8'b0001_0000,
    S_SUM  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_PUSH = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   cur_outer, cur_outer_next;
  logic   out_valid_next;
  logic   accept;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    cur_outer_next = cur_outer;
    cmd.capture    = 1'b0;
    cmd.push       = 1'b0;
    cmd.outer      = cur_outer;
    cmd.op         = cpid_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture    = 1'b1;
          cur_outer_next = req_type;
          state_next     = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op     = cpid_pkg::OP_ERR;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op     = cpid_pkg::OP_DIFF;
        state_next = S_MULP;
      end
      S_MULP: begin
        cmd.op     = cpid_pkg::OP_MULP;
        state_next = S_MULD;
      end
      S_MULD: begin
        cmd.op     = cpid_pkg::OP_MULD;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = cpid_pkg::OP_SUM;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = cpid_pkg::OP_FIN;
        // outer loop done, its output feeds the inner pass
        if (cur_outer) begin
          cur_outer_next = 1'b0;
          state_next     = S_ERR;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.push) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_outer <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_outer <= cur_outer_next;
      out_valid <= out_valid_next;
    end
  end

  `CPID_ASSERT_NEXT(a_accept_starts, accept, state == S_ERR && in_stall)
  `CPID_ASSERT_NEXT(a_outer_to_inner, state == S_FIN && cur_outer, state == S_ERR && !cur_outer)
  `CPID_ASSERT_NEXT(a_push_done, state == S_PUSH && out_free, out_valid && state == S_IDLE)
  `CPID_ASSERT(a_valid_from_push, $rose(out_valid) |-> $past(state == S_PUSH))

endmodule

// File: design/cpid_dp.sv
// datapath of the cascaded pid controller: gains, loop state and one shared multiplier
module cpid_dp #(
  parameter int FRAC_BITS = 16,
  parameter int INNER_MAX = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  cpid_pkg::cmd_t                      cmd,
  input  logic signed [31:0]                  inner_measure,
  input  logic signed [31:0]                  outer_measure,
  output logic [16:0]                         drive_out,
  output logic [30:0]                         inner_target_out
);

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint RST_IKP = (cpid_pkg::INNER_KP_NUM * ONE + cpid_pkg::INNER_KP_DEN / 2)
                               / cpid_pkg::INNER_KP_DEN;
  localparam longint RST_IKI = (cpid_pkg::INNER_KI_NUM * ONE + cpid_pkg::INNER_KI_DEN / 2)
                               / cpid_pkg::INNER_KI_DEN;
  localparam longint RST_OKP = (cpid_pkg::OUTER_KP_INT * ONE > cpid_pkg::S32_MAX) ?
                               cpid_pkg::S32_MAX : cpid_pkg::OUTER_KP_INT * ONE;
  localparam longint RST_OKI = (cpid_pkg::OUTER_KI_INT * ONE > cpid_pkg::S32_MAX) ?
                               cpid_pkg::S32_MAX : cpid_pkg::OUTER_KI_INT * ONE;
  localparam longint RST_LIM = (cpid_pkg::OUTER_LIMIT_INT * ONE > cpid_pkg::S32_MAX) ?
                               cpid_pkg::S32_MAX : cpid_pkg::OUTER_LIMIT_INT * ONE;

  // saturate a 33-bit difference to 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_hi(input logic signed [63:0] x,
                                                  input logic [31:0] hi);
    logic signed [31:0] r;
    if (x < 64'(cpid_pkg::LOOP_MIN)) begin
      r = 32'(cpid_pkg::LOOP_MIN);
    end else if (x > $signed({32'd0, hi})) begin
      r = hi;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // configuration
  logic signed [31:0] inner_kp, inner_ki, inner_kd;
  logic signed [31:0] outer_kp, outer_ki, outer_kd;
  logic signed [31:0] outer_target;
  logic [30:0]        outer_limit;

  // loop state
  logic signed [31:0] inner_err, inner_integ, inner_drive, inner_setpoint;
  logic signed [31:0] outer_err, outer_integ;

  // working registers
  logic signed [31:0] meas_i, meas_o;
  logic signed [31:0] err_cur, diff_cur;
  logic signed [63:0] prod, acc;

  logic signed [31:0] sp_sel, meas_sel, err_sel, integ_sel;
  logic signed [31:0] kp_sel, ki_sel, kd_sel;
  logic [31:0]        hi_sel;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_full;
  logic signed [31:0] integ_new, final_val;

  assign sp_sel    = cmd.outer ? outer_target : inner_setpoint;
  assign meas_sel  = cmd.outer ? meas_o : meas_i;
  assign err_sel   = cmd.outer ? outer_err : inner_err;
  assign integ_sel = cmd.outer ? outer_integ : inner_integ;
  assign kp_sel    = cmd.outer ? outer_kp : inner_kp;
  assign ki_sel    = cmd.outer ? outer_ki : inner_ki;
  assign kd_sel    = cmd.outer ? outer_kd : inner_kd;
  assign hi_sel    = cmd.outer ? {1'b0, outer_limit} : 32'(INNER_MAX);

  always_comb begin
    case (cmd.op)
      cpid_pkg::OP_DIFF: begin
        mul_a = ki_sel;
        mul_b = err_cur;
      end
      cpid_pkg::OP_MULD: begin
        mul_a = kd_sel;
        mul_b = diff_cur;
      end
      default: begin
        mul_a = kp_sel;
        mul_b = err_cur;
      end
    endcase
  end

  assign mul_full  = mul_a * mul_b;
  assign integ_new = clamp_hi(64'(integ_sel) + prod, hi_sel);
  // inner loop is incremental on the stored drive, outer is positional
  assign final_val = cmd.outer ? clamp_hi(acc, hi_sel)
                               : clamp_hi(64'(inner_drive) + acc, hi_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_kp       <= 32'(RST_IKP);
      inner_ki       <= 32'(RST_IKI);
      inner_kd       <= '0;
      outer_kp       <= 32'(RST_OKP);
      outer_ki       <= 32'(RST_OKI);
      outer_kd       <= '0;
      outer_target   <= '0;
      outer_limit    <= 31'(RST_LIM);
    end else if (cfg_write) begin
      case (cfg_index)
        cpid_pkg::REG_INNER_KP:    inner_kp     <= cfg_data;
        cpid_pkg::REG_INNER_KI:    inner_ki     <= cfg_data;
        cpid_pkg::REG_INNER_KD:    inner_kd     <= cfg_data;
        cpid_pkg::REG_OUTER_KP:    outer_kp     <= cfg_data;
        cpid_pkg::REG_OUTER_KI:    outer_ki     <= cfg_data;
        cpid_pkg::REG_OUTER_KD:    outer_kd     <= cfg_data;
        cpid_pkg::REG_OUTER_TGT:   outer_target <= cfg_data;
        cpid_pkg::REG_OUTER_LIMIT: outer_limit  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_err      <= '0;
      inner_integ    <= '0;
      inner_drive    <= '0;
      inner_setpoint <= '0;
      outer_err      <= '0;
      outer_integ    <= '0;
    end else begin
      case (cmd.op)
        cpid_pkg::OP_DIFF: begin
          if (cmd.outer) begin
            outer_err <= err_cur;
          end else begin
            inner_err <= err_cur;
          end
        end
        cpid_pkg::OP_MULP: begin
          if (cmd.outer) begin
            outer_integ <= integ_new;
          end else begin
            inner_integ <= integ_new;
          end
        end
        cpid_pkg::OP_FIN: begin
          if (cmd.outer) begin
            inner_setpoint <= final_val;
          end else begin
            inner_drive <= final_val;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_i <= inner_measure;
      meas_o <= outer_measure;
    end
    case (cmd.op)
      cpid_pkg::OP_ERR: begin
        err_cur <= sat33({sp_sel[31], sp_sel} - {meas_sel[31], meas_sel});
      end
      cpid_pkg::OP_DIFF: begin
        diff_cur <= sat33({err_sel[31], err_sel} - {err_cur[31], err_cur});
        prod     <= mul_full >>> FRAC_BITS;
      end
      cpid_pkg::OP_MULP: begin
        prod <= mul_full >>> FRAC_BITS;
      end
      cpid_pkg::OP_MULD: begin
        // integral register already holds the clamped new value
        acc  <= prod + 64'(integ_sel);
        prod <= mul_full >>> FRAC_BITS;
      end
      cpid_pkg::OP_SUM: begin
        acc <= acc + prod;
      end
      default: ;
    endcase
    if (cmd.push) begin
      drive_out        <= inner_drive[16:0];
      inner_target_out <= inner_setpoint[30:0];
    end
  end

endmodule

// File: design/cascaded_pid_controller.sv
// an inner-only step runs the inner loop; a cascade step runs the outer loop and then the inner loop
// a new request is taken only once the sequencer is back in idle, after the result is pushed
// each loop takes six sequencer steps around one shared 32x32 multiplier
// a finished result waits in the output register while the next request is taken
// reset is synchronous: gains, target and limit return to their defaults, loop state to zero
module cascaded_pid_controller #(
  parameter int FRAC_BITS = 16,
  parameter int INNER_MAX = 65536
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic signed [31:0]               inner_measure,
  input  logic signed [31:0]               outer_measure,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [16:0]                      drive_out,
  output logic [30:0]                      inner_target_out
);

  cpid_pkg::cmd_t cmd;

  cpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cpid_dp #(
    .FRAC_BITS (FRAC_BITS),
    .INNER_MAX (INNER_MAX)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .inner_measure    (inner_measure),
    .outer_measure    (outer_measure),
    .drive_out        (drive_out),
    .inner_target_out (inner_target_out)
  );

endmodule

// File: verif/cascaded_pid_controller_checker.sv
// checker for the cascaded pid controller: tracks config writes, predicts each duty result, compares
`timescale 1ns / 1ps

module cascaded_pid_controller_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpid_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            req_type,
  input  logic signed [31:0]              inner_measure,
  input  logic signed [31:0]              outer_measure,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [16:0]                     drive_out,
  input  logic [30:0]                     inner_target_out,
  output int                              fail_count,
  output int                              pending
);

  localparam int     Q_FRAC    = 16;
  localparam longint DUTY_FULL = 65536;
  localparam longint S32_MIN   = -cpid_pkg::S32_MAX - 1;

  typedef struct {
    logic [16:0] drive;
    logic [30:0] setpt;
  } duty_res_t;

  duty_res_t pending_duty[$];
  int        n_fail = 0;
  int        n_pend = 0;

  // gains, target and ceiling as seen on the config port
  longint kp_in, ki_in, kd_in, kp_out, ki_out, kd_out, tgt_out, ceil_out;
  // loop state
  longint err_in, integ_in, drive_in, setpt_in, err_out, integ_out;

  assign fail_count = n_fail;
  assign pending    = n_pend;

  function automatic longint sat(longint x, longint lo, longint hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // q16.16 product, floor rounding
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> Q_FRAC;
  endfunction

  function automatic void step_pid(logic cascade, longint meas_in, longint meas_out);
    longint prev, d, acc;
    if (cascade) begin
      prev      = err_out;
      err_out   = sat(tgt_out - meas_out, S32_MIN, cpid_pkg::S32_MAX);
      integ_out = sat(integ_out + qmul(ki_out, err_out), cpid_pkg::LOOP_MIN, ceil_out);
      d         = sat(prev - err_out, S32_MIN, cpid_pkg::S32_MAX);
      acc       = qmul(kp_out, err_out) + integ_out + qmul(kd_out, d);
      setpt_in  = sat(acc, cpid_pkg::LOOP_MIN, ceil_out);
    end
    prev     = err_in;
    err_in   = sat(setpt_in - meas_in, S32_MIN, cpid_pkg::S32_MAX);
    integ_in = sat(integ_in + qmul(ki_in, err_in), cpid_pkg::LOOP_MIN, DUTY_FULL);
    d        = sat(prev - err_in, S32_MIN, cpid_pkg::S32_MAX);
    acc      = qmul(kp_in, err_in) + integ_in + qmul(kd_in, d);
    drive_in = sat(drive_in + acc, cpid_pkg::LOOP_MIN, DUTY_FULL);
  endfunction

  always @(posedge clk) begin
    duty_res_t want;
    longint    v;
    if (rst) begin
      kp_in     = 52429;
      ki_in     = 131;
      kd_in     = 0;
      kp_out    = 5242880;
      ki_out    = 1310720;
      kd_out    = 0;
      tgt_out   = 0;
      ceil_out  = 196608000;
      err_in    = 0;
      integ_in  = 0;
      drive_in  = 0;
      setpt_in  = 0;
      err_out   = 0;
      integ_out = 0;
      pending_duty.delete();
    end else begin
      if (cfg_write) begin
        v = longint'($signed(cfg_data));
        case (cfg_index)
          cpid_pkg::REG_INNER_KP:    kp_in    = v;
          cpid_pkg::REG_INNER_KI:    ki_in    = v;
          cpid_pkg::REG_INNER_KD:    kd_in    = v;
          cpid_pkg::REG_OUTER_KP:    kp_out   = v;
          cpid_pkg::REG_OUTER_KI:    ki_out   = v;
          cpid_pkg::REG_OUTER_KD:    kd_out   = v;
          cpid_pkg::REG_OUTER_TGT:   tgt_out  = v;
          cpid_pkg::REG_OUTER_LIMIT: ceil_out = longint'({1'b0, cfg_data[30:0]});
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        step_pid(req_type, longint'(inner_measure), longint'(outer_measure));
        want.drive = drive_in[16:0];
        want.setpt = setpt_in[30:0];
        pending_duty.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_duty.size() == 0) begin
          $error("result with no request outstanding: drive_out %0d inner_target_out %0d",
                 drive_out, inner_target_out);
          n_fail++;
        end else begin
          want = pending_duty.pop_front();
          if (drive_out !== want.drive) begin
            $error("drive_out: expected %0d, actual %0d", want.drive, drive_out);
            n_fail++;
          end
          if (inner_target_out !== want.setpt) begin
            $error("inner_target_out: expected %0d, actual %0d", want.setpt,
                   inner_target_out);
            n_fail++;
          end
        end
      end
    end
    n_pend <= pending_duty.size();
  end

endmodule

// File: verif/cascaded_pid_controller_tb.sv
// testbench top for the cascaded pid controller: stimulus, config phases and verdict
`timescale 1ns / 1ps

module cascaded_pid_controller_tb;

  localparam logic INNER_ONLY = 1'b0;
  localparam logic CASCADE    = 1'b1;
  localparam int   ONE        = 65536;
  localparam int   BLOCK_REQS = 135;

  // styles of random gain sets
  localparam int CFG_MILD      = 0;
  localparam int CFG_WILD      = 1;
  localparam int CFG_ZERO_CEIL = 2;
  localparam int CFG_FULL_CEIL = 3;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_write;
  logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cpid_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            req_type;
  logic signed [31:0]              inner_measure;
  logic signed [31:0]              outer_measure;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [16:0]                     drive_out;
  logic [30:0]                     inner_target_out;
  int                              fail_count;
  int                              pending;

  int          send_idle;
  int          recv_idle;
  logic [31:0] reg_vals [0:7];

  cascaded_pid_controller dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .inner_measure    (inner_measure),
    .outer_measure    (outer_measure),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_out        (drive_out),
    .inner_target_out (inner_target_out)
  );

  cascaded_pid_controller_checker chk (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .req_type         (req_type),
    .inner_measure    (inner_measure),
    .outer_measure    (outer_measure),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .drive_out        (drive_out),
    .inner_target_out (inner_target_out),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  task automatic send_req(input logic cascade, input logic [31:0] im, input logic [31:0] om);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= cascade;
    inner_measure <= im;
    outer_measure <= om;
    do @(posedge clk); while (in_stall);
  endtask

  // pending is registered in the checker, so look only from the next edge on
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic put_reg(input logic [cpid_pkg::CFG_IDX_W-1:0] idx);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= reg_vals[idx];
    @(posedge clk);
  endtask

  // block is idle here: let the longest step finish, then write every register
  task automatic apply_config();
    drain();
    repeat (16) @(posedge clk);
    put_reg(cpid_pkg::REG_INNER_KP);
    put_reg(cpid_pkg::REG_INNER_KI);
    put_reg(cpid_pkg::REG_INNER_KD);
    put_reg(cpid_pkg::REG_OUTER_KP);
    put_reg(cpid_pkg::REG_OUTER_KI);
    put_reg(cpid_pkg::REG_OUTER_KD);
    put_reg(cpid_pkg::REG_OUTER_TGT);
    put_reg(cpid_pkg::REG_OUTER_LIMIT);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] spread(int span);
    longint v;
    v = longint'($urandom_range(2 * span)) - span;
    return v[31:0];
  endfunction

  function automatic void roll_gains(int style);
    reg_vals[cpid_pkg::REG_INNER_KP]    = $urandom_range(2 * ONE);
    reg_vals[cpid_pkg::REG_INNER_KI]    = $urandom_range(ONE / 8);
    reg_vals[cpid_pkg::REG_INNER_KD]    = spread(ONE / 2);
    reg_vals[cpid_pkg::REG_OUTER_KP]    = $urandom_range(20 * ONE);
    reg_vals[cpid_pkg::REG_OUTER_KI]    = $urandom_range(4 * ONE);
    reg_vals[cpid_pkg::REG_OUTER_KD]    = spread(ONE);
    reg_vals[cpid_pkg::REG_OUTER_TGT]   = spread(16 * ONE);
    reg_vals[cpid_pkg::REG_OUTER_LIMIT] = $urandom_range(40 * ONE, ONE);
    case (style)
      CFG_WILD: begin
        foreach (reg_vals[k]) reg_vals[k] = $urandom;
      end
      CFG_ZERO_CEIL: reg_vals[cpid_pkg::REG_OUTER_LIMIT] = 32'h0;
      CFG_FULL_CEIL: reg_vals[cpid_pkg::REG_OUTER_LIMIT] = 32'h7fff_ffff;
      default: ;
    endcase
  endfunction

  // mostly near the operating point, some full-range and rail values
  function automatic logic [31:0] pick_meas(longint center, longint span);
    longint      v;
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2) return $urandom;
    if (sel == 2) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    end
    if (span > 64'd1073741824) span = 64'd1073741824;
    v = center + longint'($urandom_range(32'(2 * span))) - span;
    return v[31:0];
  endfunction

  task automatic run_block(input int style, input int n);
    longint ceil_q, tgt_q;
    logic   cascade;
    roll_gains(style);
    apply_config();
    ceil_q = longint'({1'b0, reg_vals[cpid_pkg::REG_OUTER_LIMIT][30:0]});
    tgt_q  = longint'($signed(reg_vals[cpid_pkg::REG_OUTER_TGT]));
    for (int i = 0; i < n; i++) begin
      // hold off once per block until the pipe is empty
      if (i == n / 2) drain();
      cascade = ($urandom_range(9) < 6) ? CASCADE : INNER_ONLY;
      send_req(cascade, pick_meas(ceil_q / 2, ceil_q / 2 + ONE), pick_meas(tgt_q, 4 * ONE));
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    req_type      = INNER_ONLY;
    inner_measure = '0;
    outer_measure = '0;
    send_idle     = 18;
    recv_idle     = 65;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains, rails of both measures, inner-only steps ignore outer_measure
    send_req(CASCADE, 32'h0, 32'h0);
    send_req(CASCADE, 32'h8000_0000, 32'h8000_0000);
    send_req(INNER_ONLY, 32'h7fff_ffff, 32'h1234_5678);
    send_req(INNER_ONLY, 32'h0, 32'hdead_beef);
    send_req(CASCADE, 32'h7fff_ffff, 32'h7fff_ffff);
    send_req(CASCADE, 32'hffff_ffff, 32'hffff_ffff);
    send_req(INNER_ONLY, 32'h0001_0000, 32'h0);

    // extreme gains with a zero outer ceiling
    reg_vals[cpid_pkg::REG_INNER_KP]    = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_INNER_KI]    = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_INNER_KD]    = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_OUTER_KP]    = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_OUTER_KI]    = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_OUTER_KD]    = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_OUTER_TGT]   = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_OUTER_LIMIT] = 32'h0;
    apply_config();
    send_req(CASCADE, 32'h8000_0000, 32'h8000_0000);
    send_req(CASCADE, 32'h7fff_ffff, 32'h7fff_ffff);
    send_req(INNER_ONLY, 32'h8000_0000, 32'h0);
    send_req(CASCADE, 32'h0, 32'h8000_0000);

    // opposite rails, ceiling written with bit 31 set
    reg_vals[cpid_pkg::REG_INNER_KP]    = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_INNER_KI]    = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_INNER_KD]    = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_OUTER_KP]    = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_OUTER_KI]    = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_OUTER_KD]    = 32'h7fff_ffff;
    reg_vals[cpid_pkg::REG_OUTER_TGT]   = 32'h8000_0000;
    reg_vals[cpid_pkg::REG_OUTER_LIMIT] = 32'hffff_ffff;
    apply_config();
    send_req(CASCADE, 32'h7fff_ffff, 32'h7fff_ffff);
    send_req(CASCADE, 32'h8000_0000, 32'h8000_0000);
    send_req(INNER_ONLY, 32'h7fff_ffff, 32'h0);
    send_req(CASCADE, 32'h0, 32'h0);
    send_req(CASCADE, 32'h7fff_ffff, 32'h8000_0000);

    run_block(CFG_MILD, BLOCK_REQS);
    run_block(CFG_WILD, BLOCK_REQS);

    send_idle = 65;
    recv_idle = 18;
    run_block(CFG_ZERO_CEIL, BLOCK_REQS);
    run_block(CFG_MILD, BLOCK_REQS);

    send_idle = 0;
    recv_idle = 0;
    run_block(CFG_FULL_CEIL, BLOCK_REQS);
    run_block(CFG_MILD, BLOCK_REQS);

    drain();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
